### src/sit_pkg.sv
package sit_pkg;

	localparam int IdW    = 31;
	localparam int OrderW = 32;
	localparam int IdxW   = 6;
	localparam int CntW   = 7;
	localparam int KeyW   = OrderW + 1;

	localparam logic [1:0] ACT_ADD   = 2'd0;
	localparam logic [1:0] ACT_CLEAR = 2'd1;
	localparam logic [1:0] ACT_READ  = 2'd2;

	// one table entry as stored in the RAM
	typedef struct packed {
		logic              checked;
		logic [OrderW-1:0] order;
		logic [IdW-1:0]    id;
	} entry_t;

	localparam int EntryW = $bits(entry_t);

	typedef struct packed {
		logic              read_checked;
		logic [OrderW-1:0] read_order;
		logic [IdW-1:0]    read_id;
		logic              read_valid;
		logic [CntW-1:0]   entry_count;
		logic              accepted;
	} result_t;

	// checked entries sort last; flipping the sign bit makes signed order compare unsigned
	function automatic logic [KeyW-1:0] sort_key(input entry_t e);
		return {e.checked, ~e.order[OrderW-1], e.order[OrderW-2:0]};
	endfunction

endpackage

### src/sorted_item_table_core.sv
// Sorted item table: entries kept in order of (checked, signed order value),
// unchecked first, equal keys in arrival order.
// Input channel (s_*): one beat per command. s_tuser is the action: add, clear
// or read. An add inserts {item_id, order_key, checked}; a read returns the
// entry at read_index if it is below the current count.
// Output channel (m_*): exactly one beat per input beat, in order, carrying
// accepted, the entry count after the command and the read fields.
// A clear, a dropped add (table full), an add into an empty table, an
// out-of-range read or an unused action code goes straight to the result
// state; an in-range read first waits for the RAM data, and an add into a
// non-empty table first scans down past each entry that moves up.
// An add reads and writes the table RAM in the same cycle, shifting one entry
// per cycle from the top down to the insertion point.
// One command is worked on at a time; s_tready is high while the engine idles,
// so with a ready receiver input beats are spaced by their latency.
// A finished result sits in an output register, so the next command is taken
// while the receiver stalls; a second result then waits in the engine.
// Reset clears the entry count and the output valid flag; table contents are
// not cleared and are never shown, since only entries below the count are read.
module sorted_item_table_core import sit_pkg::*;
	#(
		parameter int CAPACITY = 64
	)
	(
		input  logic        clk,
		input  logic        arst_n,
		input  logic        s_tvalid,
		output logic        s_tready,
		input  logic [71:0] s_tdata,  // item_id, order_key, checked, read_index, pad
		input  logic [1:0]  s_tuser,  // action
		output logic        m_tvalid,
		input  logic        m_tready,
		output logic [79:0] m_tdata   // accepted, entry_count, read_valid, read_id,
		                              // read_order, read_checked, pad
	);

	entry_t          item;
	logic [IdxW-1:0] read_index;
	logic            start;
	logic            idle;
	logic            res_valid;
	result_t         res;
	logic            res_take;
	logic            out_valid_q;
	result_t         out_q;

	assign item.id      = s_tdata[30:0];
	assign item.order   = s_tdata[62:31];
	assign item.checked = s_tdata[63];
	assign read_index   = s_tdata[69:64];

	assign s_tready = idle;
	assign start    = s_tvalid && idle;

	sit_engine #(.CAPACITY(CAPACITY)) u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.action     (s_tuser),
		.item       (item),
		.read_index (read_index),
		.idle       (idle),
		.res_valid  (res_valid),
		.res        (res),
		.res_take   (res_take)
	);

	// output slot frees up in the same cycle its beat is taken
	assign res_take = res_valid && (!out_valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, out_q};

endmodule

### src/sit_ram.sv
module sit_ram
	#(
		parameter int WIDTH = 64,
		parameter int DEPTH = 64
	)
	(
		input  logic                     clk,
		input  logic                     we,
		input  logic [$clog2(DEPTH)-1:0] waddr,
		input  logic [WIDTH-1:0]         wdata,
		input  logic [$clog2(DEPTH)-1:0] raddr,
		output logic [WIDTH-1:0]         rdata
	);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

### src/sit_engine.sv
module sit_engine import sit_pkg::*;
	#(
		parameter int CAPACITY = 64
	)
	(
		input  logic            clk,
		input  logic            arst_n,
		input  logic            start,
		input  logic [1:0]      action,
		input  entry_t          item,
		input  logic [IdxW-1:0] read_index,
		output logic            idle,
		output logic            res_valid,
		output result_t         res,
		input  logic            res_take
	);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = (CW > IdxW) ? CW : IdxW;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_SCAN   = 5'b00010,
		ST_PLACE  = 5'b00100,
		ST_RDWAIT = 5'b01000,
		ST_FIN    = 5'b10000
	} state_t;

	state_t          state_q;
	logic [CW-1:0]   count_q;
	logic [CW-1:0]   pos_q;
	entry_t          new_q;
	result_t         res_q;

	logic            we;
	logic [AW-1:0]   waddr;
	entry_t          wdata;
	logic [AW-1:0]   raddr;
	entry_t          rdata;
	logic [CW-1:0]   cnt_inc;
	logic            full;
	logic            rd_hit;
	logic            greater;
	result_t         start_res;

	assign cnt_inc = count_q + CW'(1);
	assign full    = (count_q == CW'(CAPACITY));
	assign rd_hit  = IW'(read_index) < IW'(count_q);
	assign greater = sort_key(rdata) > sort_key(new_q);

	// result fields known as soon as a command is taken
	always_comb begin
		start_res             = '0;
		start_res.entry_count = CntW'(count_q);
		if (action == ACT_ADD && !full && count_q == '0) begin
			start_res.accepted    = 1'b1;
			start_res.entry_count = CntW'(cnt_inc);
		end else if (action == ACT_CLEAR) begin
			start_res.accepted    = 1'b1;
			start_res.entry_count = '0;
		end
	end

	// reads run one slot ahead of the write pointer, so the data for pos-1
	// arrives in the cycle the shift at pos is decided
	always_comb begin
		we    = 1'b0;
		waddr = AW'(pos_q);
		wdata = new_q;
		raddr = AW'(pos_q - CW'(2));
		unique case (state_q)
			ST_IDLE: begin
				if (start && action == ACT_ADD && !full && count_q == '0) begin
					we    = 1'b1;
					waddr = '0;
					wdata = item;
				end
				if (start && action == ACT_ADD) begin
					raddr = AW'(count_q - CW'(1));
				end else begin
					raddr = AW'(read_index);
				end
			end
			ST_SCAN: begin
				we = 1'b1;
				if (greater) begin
					wdata = rdata;
				end
			end
			ST_PLACE: begin
				we = 1'b1;
			end
			ST_RDWAIT, ST_FIN: begin
			end
			default: begin
			end
		endcase
	end

	sit_ram #(.WIDTH(EntryW), .DEPTH(CAPACITY)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_FIN;
						if (action == ACT_ADD && !full) begin
							if (count_q == '0) begin
								count_q <= cnt_inc;
							end else begin
								state_q <= ST_SCAN;
							end
						end else if (action == ACT_CLEAR) begin
							count_q <= '0;
						end else if (action == ACT_READ && rd_hit) begin
							state_q <= ST_RDWAIT;
						end
					end
				end
				ST_SCAN: begin
					if (!greater) begin
						count_q <= cnt_inc;
						state_q <= ST_FIN;
					end else if (pos_q == CW'(1)) begin
						state_q <= ST_PLACE;
					end
				end
				ST_PLACE: begin
					count_q <= cnt_inc;
					state_q <= ST_FIN;
				end
				ST_RDWAIT: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (res_take) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					new_q <= item;
					pos_q <= count_q;
					res_q <= start_res;
				end
			end
			ST_SCAN: begin
				if (greater) begin
					pos_q <= pos_q - CW'(1);
				end else begin
					res_q.accepted    <= 1'b1;
					res_q.entry_count <= CntW'(cnt_inc);
				end
			end
			ST_PLACE: begin
				res_q.accepted    <= 1'b1;
				res_q.entry_count <= CntW'(cnt_inc);
			end
			ST_RDWAIT: begin
				res_q.read_valid   <= 1'b1;
				res_q.read_id      <= rdata.id;
				res_q.read_order   <= rdata.order;
				res_q.read_checked <= rdata.checked;
			end
			ST_FIN: begin
			end
			default: begin
			end
		endcase
	end

	assign idle      = (state_q == ST_IDLE);
	assign res_valid = (state_q == ST_FIN);
	assign res       = res_q;

endmodule

### tb/sorted_item_table_core_tb.sv
module sorted_item_table_core_tb;
	import sit_pkg::*;

	localparam int CAP = 64;
	localparam int STALL_LIMIT = 4000;
	localparam logic [1:0] ACT_NONE = 2'd3;  // unused code, must be ignored

	typedef struct {
		logic [1:0]        action;
		logic [IdW-1:0]    id;
		logic [OrderW-1:0] order;
		logic              chk;
		logic [IdxW-1:0]   idx;
		bit                drain;  // hold this beat until all results are back
	} cmd_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [71:0] s_tdata = '0;   // item_id, order_key, checked, read_index, pad
	logic [1:0]  s_tuser = '0;   // action
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [79:0] m_tdata;        // accepted, entry_count, read_valid, read_id,
	                             // read_order, read_checked, pad

	sorted_item_table_core #(.CAPACITY(CAP)) uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	cmd_t    cmd_queue[$];
	result_t results_due[$];
	cmd_t    cmd_on_bus;

	entry_t  tbl[CAP];
	int      tbl_count = 0;

	int n_errors = 0, n_results = 0, n_beats_in = 0;
	int n_add_ok = 0, n_add_full = 0, n_read_hit = 0, n_read_miss = 0;
	int n_clear = 0, n_ignored = 0, peak_count = 0;
	int send_gap = 0, stall_left = 0, idle_cycles = 0;
	int quiet_left[2] = '{0, 0};
	bit long_stall_done = 0;

	// mostly short gaps, a few long ones, with occasional runs of no gaps at all
	function automatic int rand_gap(input int side);
		int r;
		if (quiet_left[side] > 0) begin
			quiet_left[side]--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			quiet_left[side] = $urandom_range(20, 60);
			return 0;
		end
		if (r < 45) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	function automatic bit sorts_after(input entry_t a, input entry_t b);
		if (a.checked != b.checked) return a.checked;
		return $signed(a.order) > $signed(b.order);
	endfunction

	// apply one command to the shadow table and return the result it must produce
	function automatic result_t table_apply(input cmd_t c);
		result_t r;
		entry_t  ne;
		int      pos;
		r = '0;
		case (c.action)
			ACT_ADD: begin
				if (tbl_count < CAP) begin
					ne.id = c.id;
					ne.order = c.order;
					ne.checked = c.chk;
					pos = tbl_count;
					// ties stay in front of the new entry
					while (pos > 0 && sorts_after(tbl[pos-1], ne)) begin
						tbl[pos] = tbl[pos-1];
						pos--;
					end
					tbl[pos] = ne;
					tbl_count++;
					r.accepted = 1'b1;
					n_add_ok++;
					if (tbl_count > peak_count) peak_count = tbl_count;
				end else begin
					n_add_full++;
				end
			end
			ACT_CLEAR: begin
				tbl_count = 0;
				r.accepted = 1'b1;
				n_clear++;
			end
			ACT_READ: begin
				if (c.idx < tbl_count) begin
					r.read_valid = 1'b1;
					r.read_id = tbl[c.idx].id;
					r.read_order = tbl[c.idx].order;
					r.read_checked = tbl[c.idx].checked;
					n_read_hit++;
				end else begin
					n_read_miss++;
				end
			end
			default: n_ignored++;
		endcase
		r.entry_count = tbl_count[CntW-1:0];
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: result %0d field %s mismatch: expected 0x%0h, got 0x%0h",
				$time, n_results, name, exp_v, act_v);
			n_errors++;
		end
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin : drv
		bit free;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				results_due.push_back(table_apply(cmd_on_bus));
				n_beats_in++;
			end
			free = !s_tvalid || s_tready;
			if (free) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					s_tvalid <= 1'b0;
				end else if (cmd_queue.size() > 0 &&
						!(cmd_queue[0].drain && results_due.size() > 0)) begin
					cmd_on_bus = cmd_queue.pop_front();
					s_tdata <= {2'b00, cmd_on_bus.idx, cmd_on_bus.chk, cmd_on_bus.order,
						cmd_on_bus.id};
					s_tuser <= cmd_on_bus.action;
					s_tvalid <= 1'b1;
					send_gap <= rand_gap(0);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor and receiver
	always @(posedge clk or negedge arst_n) begin : mon
		result_t got, want;
		int gap;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = result_t'(m_tdata[$bits(result_t)-1:0]);
				if (results_due.size() == 0) begin
					$display("%0t: unexpected result beat, expected none, got 0x%0h",
						$time, got);
					n_errors++;
				end else begin
					want = results_due.pop_front();
					check_field("accepted", 32'(want.accepted), 32'(got.accepted));
					check_field("entry_count", 32'(want.entry_count), 32'(got.entry_count));
					check_field("read_valid", 32'(want.read_valid), 32'(got.read_valid));
					check_field("read_id", 32'(want.read_id), 32'(got.read_id));
					check_field("read_order", want.read_order, got.read_order);
					check_field("read_checked", 32'(want.read_checked),
						32'(got.read_checked));
				end
				n_results <= n_results + 1;
			end
			if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left <= stall_left - 1;
			end else if (!long_stall_done && n_results >= 150) begin
				// long back-pressure: the sender keeps offering and must get stalled
				m_tready <= 1'b0;
				stall_left <= 400;
				long_stall_done <= 1'b1;
			end else begin
				gap = rand_gap(1);
				if (gap == 0) begin
					m_tready <= 1'b1;
				end else begin
					m_tready <= 1'b0;
					stall_left <= gap - 1;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
				if (idle_cycles >= STALL_LIMIT) begin
					$display("%0t: no beat moved for %0d cycles, %0d results outstanding",
						$time, STALL_LIMIT, results_due.size());
					$display("sorted_item_table_core_tb: done, errors");
					$finish;
				end
			end
		end
	end

	task automatic push_cmd(input logic [1:0] action, input logic [IdW-1:0] id,
			input logic [OrderW-1:0] order, input logic chk, input logic [IdxW-1:0] idx,
			input bit drain);
		cmd_t c;
		c.action = action;
		c.id = id;
		c.order = order;
		c.chk = chk;
		c.idx = idx;
		c.drain = drain;
		cmd_queue.push_back(c);
	endtask

	function automatic logic [OrderW-1:0] rand_order(input bit narrow);
		int r;
		if (narrow) return OrderW'($urandom_range(0, 6)) - OrderW'(3);
		r = $urandom_range(0, 19);
		case (r)
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h0000_0000;
			3: return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	initial begin : stim
		int n_runs, fill, est_count;
		bit narrow;
		logic [IdxW-1:0] idx;

		// directed: key extremes, both groups, a tie, reads in and out of range
		push_cmd(ACT_READ, '0, '0, 1'b0, 6'd0, 0);
		push_cmd(ACT_ADD, 31'h7fff_ffff, 32'h7fff_ffff, 1'b0, '0, 0);
		push_cmd(ACT_ADD, 31'd0, 32'h8000_0000, 1'b0, '0, 0);
		push_cmd(ACT_ADD, 31'd5, 32'd0, 1'b1, '0, 0);
		push_cmd(ACT_ADD, 31'd6, 32'h8000_0000, 1'b1, '0, 0);
		push_cmd(ACT_ADD, 31'd7, 32'd0, 1'b0, '0, 0);
		push_cmd(ACT_ADD, 31'd8, 32'd0, 1'b0, '0, 0);
		push_cmd(ACT_ADD, 31'd9, 32'hffff_ffff, 1'b0, '0, 0);
		for (int i = 0; i < 8; i++) push_cmd(ACT_READ, '0, '0, 1'b0, IdxW'(i), 0);
		push_cmd(ACT_READ, '0, '0, 1'b0, 6'd63, 0);
		push_cmd(ACT_NONE, '1, '1, 1'b1, '1, 0);
		push_cmd(ACT_CLEAR, '1, '1, 1'b1, '1, 0);
		push_cmd(ACT_READ, '0, '0, 1'b0, 6'd0, 0);
		push_cmd(ACT_ADD, 31'h2aaa_aaaa, 32'h5555_5555, 1'b1, 6'h2a, 0);
		push_cmd(ACT_READ, '0, '0, 1'b0, 6'd0, 0);
		push_cmd(ACT_CLEAR, '0, '0, 1'b0, '0, 0);

		// random: runs of adds with reads mixed in, some filling past capacity,
		// each closed by a clear
		n_runs = 0;
		while (cmd_queue.size() < 700) begin
			fill = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 75) : $urandom_range(1, 30);
			narrow = $urandom_range(0, 2) == 0;
			est_count = 0;
			for (int i = 0; i < fill; i++) begin
				push_cmd(ACT_ADD, IdW'($urandom), rand_order(narrow),
					1'($urandom_range(0, 1)), IdxW'($urandom),
					(i == 0) && (n_runs == 2 || $urandom_range(0, 9) == 0));
				if (est_count < CAP) est_count++;
				if ($urandom_range(0, 99) < 40) begin
					idx = ($urandom_range(0, 1) == 0) ? IdxW'($urandom_range(0, est_count - 1))
						: IdxW'($urandom_range(0, 63));
					push_cmd(ACT_READ, IdW'($urandom), $urandom, 1'($urandom_range(0, 1)),
						idx, 0);
				end
				if ($urandom_range(0, 99) < 3)
					push_cmd(ACT_NONE, IdW'($urandom), $urandom, 1'($urandom_range(0, 1)),
						IdxW'($urandom), 0);
			end
			for (int i = 0; i < $urandom_range(2, 8); i++)
				push_cmd(ACT_READ, IdW'($urandom), $urandom, 1'($urandom_range(0, 1)),
					IdxW'($urandom_range(0, est_count - 1)), 0);
			push_cmd(ACT_CLEAR, IdW'($urandom), $urandom, 1'($urandom_range(0, 1)),
				IdxW'($urandom), 0);
			n_runs++;
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		while (cmd_queue.size() > 0 || s_tvalid) @(posedge clk);
		while (results_due.size() > 0) @(posedge clk);
		repeat (80) @(posedge clk);

		$display("%0d commands in %0d runs: %0d adds stored, %0d adds to a full table, %0d clears",
			n_beats_in, n_runs, n_add_ok, n_add_full, n_clear);
		$display("reads: %0d in range, %0d out of range; %0d unused codes; peak count %0d",
			n_read_hit, n_read_miss, n_ignored, peak_count);
		if (n_errors == 0) begin
			$display("sorted_item_table_core_tb: done, clean");
		end else begin
			$display("sorted_item_table_core_tb: done, errors");
		end
		$finish;
	end

endmodule
